/* rtl/lcas_pkg.sv */
// Shared types and constants for the load cycle actuator sequencer.
// No dependencies; every other file of the block except lcas_checker imports this package.
package lcas_pkg;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 23;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FULL_LOAD        = 8'd0,
        REG_RAMP_STEP        = 8'd1,
        REG_RAMP_INTERVAL_MS = 8'd2,
        REG_HOLD_TIME_MS     = 8'd3,
        REG_HOLD_TOLERANCE   = 8'd4,
        REG_DRIVE_DEADBAND   = 8'd5,
        REG_MAX_FORWARD_PWM  = 8'd6,
        REG_MAX_REVERSE_PWM  = 8'd7
    } cfg_reg_idx_t;

    // Register values after reset
    localparam logic [22:0] RST_FULL_LOAD        = 23'd7680;
    localparam logic [22:0] RST_RAMP_STEP        = 23'd2560;
    localparam logic [15:0] RST_RAMP_INTERVAL_MS = 16'd50;
    localparam logic [15:0] RST_HOLD_TIME_MS     = 16'd2000;
    localparam logic [22:0] RST_HOLD_TOLERANCE   = 23'd256;
    localparam logic [11:0] RST_DRIVE_DEADBAND   = 12'd80;
    localparam logic [7:0]  RST_MAX_FORWARD_PWM  = 8'd255;
    localparam logic [7:0]  RST_MAX_REVERSE_PWM  = 8'd255;

    typedef struct packed {
        logic [22:0] full_load;
        logic [22:0] ramp_step;
        logic [15:0] ramp_interval_ms;
        logic [15:0] hold_time_ms;
        logic [22:0] hold_tolerance;
        logic [11:0] drive_deadband;
        logic [7:0]  max_forward_pwm;
        logic [7:0]  max_reverse_pwm;
    } lcas_cfg_t;

    // Hold sequencer outcome for one step
    typedef struct packed {
        logic        switched;
        logic        loading;
        logic [15:0] cycle_total;
    } lcas_hold_res_t;

endpackage

/* rtl/lcas_ifs.sv */
// Channel interfaces of the load cycle actuator sequencer: input word,
// result word and configuration write. Depends on lcas_pkg.
interface lcas_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] now_ms;
    logic signed [23:0] load_sample;
    logic signed [12:0] drive_value;

    modport source (output valid, now_ms, load_sample, drive_value, input ready);
    modport sink   (input valid, now_ms, load_sample, drive_value, output ready);
endinterface

interface lcas_out_if;
    logic               valid;
    logic               ready;
    logic               extend;
    logic        [7:0]  pwm_duty;
    logic signed [23:0] ramped_target;
    logic        [22:0] current_target;
    logic        [15:0] cycle_total;
    logic               target_switched;

    modport source (output valid, extend, pwm_duty, ramped_target, current_target,
                    cycle_total, target_switched, input ready);
    modport sink   (input valid, extend, pwm_duty, ramped_target, current_target,
                    cycle_total, target_switched, output ready);
endinterface

interface lcas_cfg_if
    import lcas_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/lcas_cfg_regs.sv */
// Configuration register file of the sequencer.
// Depends on lcas_pkg and lcas_cfg_if.
module lcas_cfg_regs
    import lcas_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    lcas_cfg_if.sink        cfg,
    output lcas_cfg_t       regs
);

    lcas_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.full_load        <= RST_FULL_LOAD;
            regs_reg.ramp_step        <= RST_RAMP_STEP;
            regs_reg.ramp_interval_ms <= RST_RAMP_INTERVAL_MS;
            regs_reg.hold_time_ms     <= RST_HOLD_TIME_MS;
            regs_reg.hold_tolerance   <= RST_HOLD_TOLERANCE;
            regs_reg.drive_deadband   <= RST_DRIVE_DEADBAND;
            regs_reg.max_forward_pwm  <= RST_MAX_FORWARD_PWM;
            regs_reg.max_reverse_pwm  <= RST_MAX_REVERSE_PWM;
        end
        else if (cfg.valid)
        begin
            // drop writes beyond the register list
            unique case (cfg.addr)
                REG_FULL_LOAD:        regs_reg.full_load        <= cfg.data[22:0];
                REG_RAMP_STEP:        regs_reg.ramp_step        <= cfg.data[22:0];
                REG_RAMP_INTERVAL_MS: regs_reg.ramp_interval_ms <= cfg.data[15:0];
                REG_HOLD_TIME_MS:     regs_reg.hold_time_ms     <= cfg.data[15:0];
                REG_HOLD_TOLERANCE:   regs_reg.hold_tolerance   <= cfg.data[22:0];
                REG_DRIVE_DEADBAND:   regs_reg.drive_deadband   <= cfg.data[11:0];
                REG_MAX_FORWARD_PWM:  regs_reg.max_forward_pwm  <= cfg.data[7:0];
                REG_MAX_REVERSE_PWM:  regs_reg.max_reverse_pwm  <= cfg.data[7:0];
                default:              ;
            endcase
        end
    end

endmodule

/* rtl/lcas_ramp.sv */
// Rate-limited setpoint ramp: holds the ramp value and the last move time.
// Depends on lcas_pkg.
module lcas_ramp
    import lcas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  lcas_cfg_t          regs,
    input  logic        [22:0] target,
    input  logic        [31:0] now_ms,
    output logic signed [23:0] ramp_next
);

    logic signed [23:0] ramp_reg;
    logic        [31:0] last_time_reg;
    logic        [31:0] elapsed;
    logic               move;
    logic signed [24:0] target_s;
    logic signed [24:0] ramp_s;
    logic signed [24:0] diff;
    logic        [24:0] diff_mag;
    logic signed [24:0] step_s;
    logic signed [24:0] moved;

    assign elapsed  = now_ms - last_time_reg;
    assign move     = elapsed >= {16'd0, regs.ramp_interval_ms};
    assign target_s = signed'({2'b00, target});
    assign ramp_s   = {ramp_reg[23], ramp_reg};
    assign step_s   = signed'({2'b00, regs.ramp_step});
    assign diff     = target_s - ramp_s;
    assign diff_mag = diff[24] ? 25'(-diff) : 25'(diff);

    always_comb
    begin
        priority if (diff_mag <= {2'b00, regs.ramp_step})
            moved = target_s;
        else if (!diff[24])
            moved = ramp_s + step_s;
        else
            moved = ramp_s - step_s;
    end

    assign ramp_next = move ? moved[23:0] : ramp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg      <= '0;
            last_time_reg <= '0;
        end
        else if (step_en && move)
        begin
            ramp_reg      <= moved[23:0];
            last_time_reg <= now_ms;
        end
    end

endmodule

/* rtl/lcas_drive_map.sv */
// Drive to direction and PWM duty, with deadband and per-direction limits.
// Depends on lcas_pkg.
module lcas_drive_map
    import lcas_pkg::*;
(
    input  lcas_cfg_t          regs,
    input  logic signed [12:0] drive_value,
    output logic               extend,
    output logic        [7:0]  pwm_duty
);

    logic [12:0] drive_mag;
    logic        positive;
    logic        active;
    logic [8:0]  raw_duty;
    logic [7:0]  limit;

    assign drive_mag = drive_value[12] ? 13'(-drive_value) : 13'(drive_value);
    assign positive  = !drive_value[12] && (drive_value != 13'sd0);
    assign active    = drive_mag > {1'b0, regs.drive_deadband};
    assign raw_duty  = drive_mag[12:4];
    assign limit     = positive ? regs.max_forward_pwm : regs.max_reverse_pwm;

    always_comb
    begin
        if (active)
        begin
            extend   = positive;
            pwm_duty = (raw_duty < {1'b0, limit}) ? raw_duty[7:0] : limit;
        end
        else
        begin
            extend   = 1'b1;
            pwm_duty = 8'd0;
        end
    end

endmodule

/* rtl/lcas_hold.sv */
// Hold window timer, load/unload phase and cycle counter.
// Depends on lcas_pkg.
module lcas_hold
    import lcas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  lcas_cfg_t          regs,
    input  logic        [31:0] now_ms,
    input  logic signed [23:0] load_sample,
    output logic               loading,
    output lcas_hold_res_t     res
);

    logic               hold_active_reg;
    logic        [31:0] hold_start_reg;
    logic               loading_reg;
    logic        [15:0] cycle_reg;
    logic        [22:0] target;
    logic signed [24:0] err;
    logic        [24:0] err_mag;
    logic               in_tol;
    logic        [31:0] start_eff;
    logic        [31:0] held;
    logic               expire;

    assign loading   = loading_reg;
    assign target    = loading_reg ? regs.full_load : 23'd0;
    assign err       = signed'({2'b00, target}) - {load_sample[23], load_sample};
    assign err_mag   = err[24] ? 25'(-err) : 25'(err);
    assign in_tol    = err_mag < {2'b00, regs.hold_tolerance};
    assign start_eff = hold_active_reg ? hold_start_reg : now_ms;
    assign held      = now_ms - start_eff;
    assign expire    = in_tol && (held >= {16'd0, regs.hold_time_ms});

    assign res.switched    = expire;
    assign res.loading     = loading_reg ^ expire;
    assign res.cycle_total = (expire && !loading_reg) ? cycle_reg + 16'd1 : cycle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active_reg <= 1'b0;
            hold_start_reg  <= '0;
            loading_reg     <= 1'b1;
            cycle_reg       <= '0;
        end
        else if (step_en)
        begin
            hold_active_reg <= in_tol && !expire;
            if (in_tol && !hold_active_reg)
                hold_start_reg <= now_ms;
            loading_reg <= res.loading;
            cycle_reg   <= res.cycle_total;
        end
    end

endmodule

/* rtl/load_cycle_actuator_sequencer.sv */
// Load cycle actuator sequencer, top level.
// Pipeline: an accepted input word goes into the input register, then through one step of logic
// into the result register, where the result word becomes valid.
// Throughput: one word per cycle; a stalled result word holds the input register.
// Reset (rst_n, asynchronous, active low): registers to defaults, ramp 0, loading phase,
// cycle count 0, both pipeline stages empty. Depends on lcas_pkg and the lcas_* modules.
module load_cycle_actuator_sequencer
    import lcas_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lcas_in_if.sink      in_ch,
    lcas_out_if.source   out_ch,
    lcas_cfg_if.sink     cfg
);

    // Input stage: hold one accepted word until the step logic takes it.
    logic               s1_valid_reg;
    logic        [31:0] s1_now_reg;
    logic signed [23:0] s1_load_reg;
    logic signed [12:0] s1_drive_reg;

    // Result stage
    logic               out_valid_reg;
    logic               extend_reg;
    logic        [7:0]  duty_reg;
    logic signed [23:0] ramp_reg;
    logic        [22:0] target_reg;
    logic        [15:0] cycle_reg;
    logic               switched_reg;

    lcas_cfg_t          regs;
    logic               advance;
    logic               step_en;
    logic               loading;
    logic        [22:0] target;
    logic signed [23:0] ramp_next;
    logic               extend;
    logic        [7:0]  pwm_duty;
    lcas_hold_res_t     hold_res;

    // Advance the result stage whenever it is empty or being taken; the
    // input stage refills in the same cycle, so a word may enter every cycle while the result stage advances.
    assign advance     = !out_valid_reg || out_ch.ready;
    assign step_en     = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;

    // Target in force before this step drives the ramp; lcas_hold forms the same target for its hold test.
    assign target = loading ? regs.full_load : 23'd0;

    lcas_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lcas_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .regs      (regs),
        .target    (target),
        .now_ms    (s1_now_reg),
        .ramp_next (ramp_next)
    );

    lcas_drive_map u_drive_map (
        .regs        (regs),
        .drive_value (s1_drive_reg),
        .extend      (extend),
        .pwm_duty    (pwm_duty)
    );

    lcas_hold u_hold (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .regs        (regs),
        .now_ms      (s1_now_reg),
        .load_sample (s1_load_reg),
        .loading     (loading),
        .res         (hold_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_now_reg   <= in_ch.now_ms;
            s1_load_reg  <= in_ch.load_sample;
            s1_drive_reg <= in_ch.drive_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Capture the result word; hold it while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            extend_reg   <= extend;
            duty_reg     <= pwm_duty;
            ramp_reg     <= ramp_next;
            target_reg   <= hold_res.loading ? regs.full_load : 23'd0;
            cycle_reg    <= hold_res.cycle_total;
            switched_reg <= hold_res.switched;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.extend          = extend_reg;
    assign out_ch.pwm_duty        = duty_reg;
    assign out_ch.ramped_target   = ramp_reg;
    assign out_ch.current_target  = target_reg;
    assign out_ch.cycle_total     = cycle_reg;
    assign out_ch.target_switched = switched_reg;

endmodule

/* rtl/lcas_checker.sv */
// Port-level checker for the load cycle actuator sequencer and its bind.
// Depends on the top level load_cycle_actuator_sequencer.
module lcas_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic        [7:0]  pwm_duty,
    input logic signed [23:0] ramped_target,
    input logic        [15:0] cycle_total
);

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its duty, ramped target and cycle count.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(pwm_duty) && $stable(ramped_target) && $stable(cycle_total))
        else $error("result word changed while stalled");

    // Back-pressure only ever comes from a stalled result stage.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // The ramp never goes negative.
    a_ramp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ramped_target[23])
        else $error("ramped setpoint went negative");

endmodule

bind load_cycle_actuator_sequencer lcas_checker u_lcas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pwm_duty      (out_ch.pwm_duty),
    .ramped_target (out_ch.ramped_target),
    .cycle_total   (out_ch.cycle_total)
);

/* tb/lcas_tb_pkg.sv */
`timescale 1ns / 1ps
// Result word layout and the cycle tracker that predicts and checks the sequencer.
// Depends on lcas_pkg for the register indexes, the reset values and lcas_cfg_t.
package lcas_tb_pkg;
    import lcas_pkg::*;

    // Indexes that name no register; writes to them must leave the block unchanged
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 8'd8;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 8'hFF;

    typedef struct packed {
        logic        extend;
        logic [7:0]  pwm_duty;
        logic [23:0] ramped_target;
        logic [22:0] current_target;
        logic [15:0] cycle_total;
        logic        target_switched;
    } lcas_result_t;

    class sequencer_tracker;
        lcas_cfg_t    cfg;
        longint       ramp_val;
        logic [31:0]  last_ramp_ms;
        logic         hold_on;
        logic [31:0]  hold_start_ms;
        logic         loading;
        logic [15:0]  cycles_done;
        lcas_result_t due_words[$];
        int           err_count;

        function new();
            cfg.full_load        = RST_FULL_LOAD;
            cfg.ramp_step        = RST_RAMP_STEP;
            cfg.ramp_interval_ms = RST_RAMP_INTERVAL_MS;
            cfg.hold_time_ms     = RST_HOLD_TIME_MS;
            cfg.hold_tolerance   = RST_HOLD_TOLERANCE;
            cfg.drive_deadband   = RST_DRIVE_DEADBAND;
            cfg.max_forward_pwm  = RST_MAX_FORWARD_PWM;
            cfg.max_reverse_pwm  = RST_MAX_REVERSE_PWM;
            ramp_val      = 0;
            last_ramp_ms  = '0;
            hold_on       = 1'b0;
            hold_start_ms = '0;
            loading       = 1'b1;
            cycles_done   = '0;
            err_count     = 0;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint active_target();
            return loading ? longint'(cfg.full_load) : 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FULL_LOAD:        cfg.full_load        = val;
                REG_RAMP_STEP:        cfg.ramp_step        = val;
                REG_RAMP_INTERVAL_MS: cfg.ramp_interval_ms = val[15:0];
                REG_HOLD_TIME_MS:     cfg.hold_time_ms     = val[15:0];
                REG_HOLD_TOLERANCE:   cfg.hold_tolerance   = val;
                REG_DRIVE_DEADBAND:   cfg.drive_deadband   = val[11:0];
                REG_MAX_FORWARD_PWM:  cfg.max_forward_pwm  = val[7:0];
                REG_MAX_REVERSE_PWM:  cfg.max_reverse_pwm  = val[7:0];
                default: ;
            endcase
        endfunction

        // One control iteration: ramp, then drive mapping, then the hold window
        function void take_iteration(logic [31:0] now, logic signed [23:0] load,
                                     logic signed [12:0] drive);
            longint       tgt;
            longint       diff;
            longint       lv;
            longint       dv;
            longint       amp;
            longint       lim;
            logic [31:0]  elapsed;
            lcas_result_t w;

            tgt = active_target();
            lv  = longint'(load);
            dv  = longint'(drive);
            w.target_switched = 1'b0;

            elapsed = now - last_ramp_ms;
            if (elapsed >= {16'h0, cfg.ramp_interval_ms}) begin
                last_ramp_ms = now;
                diff = tgt - ramp_val;
                if (magnitude(diff) <= longint'(cfg.ramp_step))
                    ramp_val = tgt;
                else if (diff > 0)
                    ramp_val = ramp_val + longint'(cfg.ramp_step);
                else
                    ramp_val = ramp_val - longint'(cfg.ramp_step);
            end

            amp = magnitude(dv);
            if (amp > longint'(cfg.drive_deadband)) begin
                lim = (dv > 0) ? longint'(cfg.max_forward_pwm) : longint'(cfg.max_reverse_pwm);
                w.extend   = (dv > 0);
                w.pwm_duty = ((amp >>> 4) < lim) ? 8'(amp >>> 4) : 8'(lim);
            end else begin
                w.extend   = 1'b1;
                w.pwm_duty = '0;
            end

            if (magnitude(tgt - lv) < longint'(cfg.hold_tolerance)) begin
                if (!hold_on) begin
                    hold_start_ms = now;
                    hold_on       = 1'b1;
                end
                elapsed = now - hold_start_ms;
                if (elapsed >= {16'h0, cfg.hold_time_ms}) begin
                    loading = !loading;
                    if (loading)
                        cycles_done = cycles_done + 16'd1;
                    hold_on           = 1'b0;
                    w.target_switched = 1'b1;
                end
            end else begin
                hold_on = 1'b0;
            end

            w.ramped_target  = ramp_val[23:0];
            w.current_target = loading ? cfg.full_load : '0;
            w.cycle_total    = cycles_done;
            due_words.push_back(w);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                err_count++;
            end
        endfunction

        function void match_output(lcas_result_t got);
            lcas_result_t want;
            if (due_words.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
                return;
            end
            want = due_words.pop_front();
            compare_field("extend", 32'(want.extend), 32'(got.extend));
            compare_field("pwm_duty", 32'(want.pwm_duty), 32'(got.pwm_duty));
            compare_field("ramped_target", 32'(want.ramped_target),
                          32'(got.ramped_target));
            compare_field("current_target", 32'(want.current_target),
                          32'(got.current_target));
            compare_field("cycle_total", 32'(want.cycle_total), 32'(got.cycle_total));
            compare_field("target_switched", 32'(want.target_switched),
                          32'(got.target_switched));
        endfunction
    endclass

endpackage

/* tb/tb_load_cycle_actuator_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking bench for load_cycle_actuator_sequencer: directed words, then random phases.
// Depends on lcas_pkg, the lcas_* channel interfaces, the block, and lcas_tb_pkg.
module tb_load_cycle_actuator_sequencer;
    import lcas_pkg::*;
    import lcas_tb_pkg::*;

    // Far above the slowest legal run (about a thousand words)
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          WORDS_PER_PHASE = 150;
    localparam int          RANDOM_PHASES = 6;

    logic clk = 1'b0;
    logic rst_n;

    lcas_in_if  in_ch();
    lcas_out_if out_ch();
    lcas_cfg_if cfg_ch();

    load_cycle_actuator_sequencer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    sequencer_tracker tracker;
    int               send_idle_pct;
    int               recv_idle_pct;
    int unsigned      cycle_count = 0;
    logic [31:0]      clock_ms;

    // 10 ns clock; starts low so no edge falls at time zero
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: give up on a run that stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: drop ready at random according to the current idling mode
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: every accepted result word goes against the oldest prediction
    always @(posedge clk)
    begin
        lcas_result_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.extend          = out_ch.extend;
            got.pwm_duty        = out_ch.pwm_duty;
            got.ramped_target   = out_ch.ramped_target;
            got.current_target  = out_ch.current_target;
            got.cycle_total     = out_ch.cycle_total;
            got.target_switched = out_ch.target_switched;
            tracker.match_output(got);
        end
    end

    // 0: sender idles 29%, receiver 69%; 1: the other way round; else no idling
    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 29;
                recv_idle_pct = 69;
            end
            1:
            begin
                send_idle_pct = 69;
                recv_idle_pct = 29;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one input word; entered and left at a falling edge. Valid stays high on exit,
    // so back-to-back words never see valid lowered and raised in one step.
    task automatic send_word(logic [31:0] now, logic signed [23:0] load,
                             logic signed [12:0] drive);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.now_ms      <= now;
        in_ch.load_sample <= load;
        in_ch.drive_value <= drive;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.take_iteration(now, load, drive);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted word has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        // let the pipeline run dry before touching registers
        repeat (3) @(negedge clk);
    endtask

    // One register write; valid is left high so consecutive writes run back to back
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.set_reg(idx, val);
        @(negedge clk);
    endtask

    // Write every register, then a stray index that must be ignored
    task automatic program_regs(int unsigned tl, int unsigned rs, int unsigned ri,
                                int unsigned ht, int unsigned tol, int unsigned db,
                                int unsigned fwd, int unsigned rev);
        write_reg(REG_FULL_LOAD, CFG_DATA_W'(tl));
        write_reg(REG_RAMP_STEP, CFG_DATA_W'(rs));
        write_reg(REG_RAMP_INTERVAL_MS, CFG_DATA_W'(ri));
        write_reg(REG_HOLD_TIME_MS, CFG_DATA_W'(ht));
        write_reg(REG_HOLD_TOLERANCE, CFG_DATA_W'(tol));
        write_reg(REG_DRIVE_DEADBAND, CFG_DATA_W'(db));
        write_reg(REG_MAX_FORWARD_PWM, CFG_DATA_W'(fwd));
        write_reg(REG_MAX_REVERSE_PWM, CFG_DATA_W'(rev));
        write_reg($urandom_range(1) ? REG_SPARE_FIRST : REG_SPARE_LAST,
                  CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly a narrow range, now and then anywhere up to the register's limit
    function automatic int unsigned pick_range(int unsigned lo, int unsigned near_hi,
                                               int unsigned far_hi);
        if ($urandom_range(3) != 0)
            return $urandom_range(near_hi, lo);
        return $urandom_range(far_hi, lo);
    endfunction

    // Build one control iteration. Time mostly creeps forward and the load mostly sits
    // near the target in force, so the hold window fills and the target toggles often;
    // the rest is time jumps, wraps, far-off loads and deadband edges.
    task automatic next_iteration(output logic [31:0] now, output logic signed [23:0] load,
                                  output logic signed [12:0] drive);
        longint tgt;
        longint spread;
        longint tol;
        longint lv;
        int     dv;
        int     db;
        int     r;

        r = $urandom_range(99);
        if (r < 60)
            clock_ms = clock_ms + $urandom_range(8);
        else if (r < 85)
            clock_ms = clock_ms + $urandom_range(300);
        else if (r < 95)
            clock_ms = clock_ms + $urandom_range(70000);
        else
            clock_ms = $urandom;
        now = clock_ms;

        tgt    = tracker.active_target();
        tol    = longint'(tracker.cfg.hold_tolerance);
        spread = tol + 2;
        r = $urandom_range(99);
        if (r < 65)
            lv = tgt + longint'($urandom_range(32'(2 * spread))) - spread;
        else if (r < 80)
            lv = tgt + ($urandom_range(1) ? tol : tol - 1) * ($urandom_range(1) ? 1 : -1);
        else if (r < 90)
            lv = ((tgt == 0) ? longint'(tracker.cfg.full_load) : 0)
                 + longint'($urandom_range(64)) - 32;
        else
            lv = longint'($urandom);
        load = lv[23:0];

        db = int'(tracker.cfg.drive_deadband);
        r  = $urandom_range(99);
        if (r < 40)
            dv = int'($urandom_range(8160)) - 4080;
        else if (r < 75)
        begin
            dv = db + int'($urandom_range(1));
            if (dv > 4080)
                dv = 4080;
            if ($urandom_range(1))
                dv = -dv;
        end
        else if (r < 85)
            dv = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 4080 : -4080);
        else
            dv = int'($urandom_range(64)) - 32;
        drive = dv[12:0];
    endtask

    initial
    begin
        logic [31:0]        now;
        logic signed [23:0] load;
        logic signed [12:0] drive;

        tracker     = new();
        clock_ms    = '0;
        set_idling(0);

        // Every input known from time zero, with reset asserted
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.now_ms       <= '0;
        in_ch.load_sample  <= '0;
        in_ch.drive_value  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.addr        <= REG_FULL_LOAD;
        cfg_ch.data        <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: field extremes, deadband edges, a full hold and a time wrap
        send_word(32'd0, 0, 0);
        send_word(32'd10, 8388607, 4080);
        send_word(32'd60, -8388608, -4080);
        send_word(32'd61, 7680, 80);
        send_word(32'd120, 7680, 81);
        send_word(32'd200, 7700, -81);
        send_word(32'd2200, 7680, -80);
        send_word(32'hFFFF_FFF0, 0, 1);
        send_word(32'h0000_0010, 100, -1);
        settle();

        // Widest limits, zero duty limits, zero interval and zero hold time:
        // the target toggles on every step in tolerance
        program_regs(8388607, 8388607, 0, 0, 8388607, 0, 0, 0);
        send_word(32'd100, 0, 1);
        send_word(32'd100, 8388607, -1);
        send_word(32'd101, -8388608, 4080);
        send_word(32'd101, 0, -4080);
        settle();

        // Zero ramp step, zero tolerance and the largest deadband: nothing moves
        program_regs(5000, 0, 0, 3, 0, 4080, 200, 100);
        send_word(32'd102, 5000, 4080);
        send_word(32'd110, 5000, -4080);
        send_word(32'd120, 4999, 0);
        settle();

        // Unit ramp step, duty limits biting, short hold so the target returns
        program_regs(5000, 1, 0, 3, 100, 15, 200, 100);
        send_word(32'd130, 5000, 16);
        send_word(32'd131, 4950, -300);
        send_word(32'd134, 5040, 4080);
        send_word(32'd135, 20, -4080);
        send_word(32'd140, 0, 15);
        send_word(32'd143, -99, -16);
        settle();

        clock_ms = 32'd200;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_idling(ph / 2);
            case (ph)
                0: program_regs($urandom_range(20000, 256), $urandom_range(3000, 1),
                                $urandom_range(20), $urandom_range(40),
                                $urandom_range(600, 8), $urandom_range(300),
                                $urandom_range(255), $urandom_range(255));
                1: program_regs(8388607, 8388607, 65535, 65535, 8388607, 4080, 255, 255);
                2: program_regs(0, 1, 0, 0, 0, 0, 0, 0);
                default: program_regs(pick_range(0, 20000, 8388607),
                                      pick_range(1, 4000, 8388607),
                                      pick_range(0, 30, 65535),
                                      pick_range(0, 80, 65535),
                                      pick_range(0, 2000, 8388607),
                                      pick_range(0, 200, 4080),
                                      $urandom_range(255), $urandom_range(255));
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // now and then hold the sender until the pipeline has emptied
                if ($urandom_range(99) == 0)
                    settle();
                next_iteration(now, load, drive);
                send_word(now, load, drive);
            end
            settle();
        end

        // Drained above; give any stray word a chance to show before the verdict
        repeat (8) @(posedge clk);
        if (tracker.err_count == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/lcas_pkg.sv
rtl/lcas_ifs.sv
rtl/lcas_cfg_regs.sv
rtl/lcas_ramp.sv
rtl/lcas_drive_map.sv
rtl/lcas_hold.sv
rtl/load_cycle_actuator_sequencer.sv
rtl/lcas_checker.sv
tb/lcas_tb_pkg.sv
tb/tb_load_cycle_actuator_sequencer.sv
